/* rtl/qpie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpie_pkg
// shared types, character codes and register indexes for the query string
// integer parameter extractor
// ----------------------------------------------------------------------------
package qpie_pkg;

    localparam int DEF_MAX_VALUE_CHARS = 9;
    localparam int DEF_MAX_KEY_CHARS   = 8;

    localparam int KEY_NAME_W  = 64;
    localparam int KEY_BYTES   = KEY_NAME_W / 8;
    localparam int KEY_LEN_W   = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int MAG_W       = 30;
    localparam int VALUE_W     = 31;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_NAME   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 1'b1;

    // character codes
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [1:0] {
        SEG_KEY,
        SEG_VALUE,
        SEG_SKIP,
        SEG_DONE
    } seg_status_t;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } num_phase_t;

    typedef struct packed {
        logic [7:0] query_byte;
        logic       last_byte;
    } qpie_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] param_value;
        logic                      key_found;
    } qpie_result_t;

endpackage

/* rtl/query_param_int_extractor.sv */
`timescale 1ns / 1ps
// a byte is held in the input register and parsed by the parser stage; on the
// last byte the result is loaded into the result register that drives the outputs
// throughput: one query byte per cycle, set by the single parser stage between the
// input and result registers; a last byte waits only while the result register is full
// reset: rst_n clears the parser state, the key registers and both valid flags
// ----------------------------------------------------------------------------
// query_param_int_extractor
// finds the first '&'-separated segment whose key matches the configured key,
// followed by '=', and parses its value like a %d conversion
// ----------------------------------------------------------------------------
module query_param_int_extractor
#(
    parameter int MAX_VALUE_CHARS = qpie_pkg::DEF_MAX_VALUE_CHARS,
    parameter int MAX_KEY_CHARS   = qpie_pkg::DEF_MAX_KEY_CHARS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // config write port
    input  logic                                cfg_write,
    input  logic [qpie_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [qpie_pkg::KEY_NAME_W-1:0]     cfg_data,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          query_byte,
    input  logic                                last_byte,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qpie_pkg::VALUE_W-1:0] param_value,
    output logic                                key_found
);

    // key registers
    logic [qpie_pkg::KEY_NAME_W-1:0] key_name_reg;
    logic [qpie_pkg::KEY_LEN_W-1:0]  key_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_name_reg   <= '0;
            key_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                qpie_pkg::REG_KEY_NAME:   key_name_reg   <= cfg_data;
                qpie_pkg::REG_KEY_LENGTH: key_length_reg <= cfg_data[qpie_pkg::KEY_LEN_W-1:0];
                default:                  key_name_reg   <= key_name_reg;
            endcase
        end
    end

    qpie_pkg::qpie_item_t   in_item;
    qpie_pkg::qpie_item_t   item;
    qpie_pkg::qpie_result_t parse_result;
    qpie_pkg::qpie_result_t out_result;
    logic                   item_valid;
    logic                   slot_free;
    logic                   advance;
    logic                   step;

    assign in_item.query_byte = query_byte;
    assign in_item.last_byte  = last_byte;

    // a byte that ends a query needs room in the result register;
    // any other byte moves on unconditionally
    assign advance = !item.last_byte || slot_free;
    assign step    = item_valid && advance;

    // input register stage
    qpie_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // segment match and number parse
    qpie_parser
    #(
        .MAX_VALUE_CHARS (MAX_VALUE_CHARS),
        .MAX_KEY_CHARS   (MAX_KEY_CHARS)
    )
    u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item),
        .key_name   (key_name_reg),
        .key_length (key_length_reg),
        .result     (parse_result)
    );

    // result register, loaded on the last byte of each query
    qpie_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && item.last_byte),
        .load_result (parse_result),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot_free   (slot_free),
        .result      (out_result)
    );

    assign param_value = out_result.param_value;
    assign key_found   = out_result.key_found;

endmodule

/* rtl/qpie_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpie_in_reg
// input register: holds one request byte until the parser takes it
// ----------------------------------------------------------------------------
module qpie_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qpie_pkg::qpie_item_t in_item,
    input  logic               advance,
    output logic               item_valid,
    output qpie_pkg::qpie_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    qpie_pkg::qpie_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/qpie_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpie_parser
// segment matcher and %d-style number parser, one byte per step
// ----------------------------------------------------------------------------
module qpie_parser
#(
    parameter int MAX_VALUE_CHARS = qpie_pkg::DEF_MAX_VALUE_CHARS,
    parameter int MAX_KEY_CHARS   = qpie_pkg::DEF_MAX_KEY_CHARS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  qpie_pkg::qpie_item_t              item,
    input  logic [qpie_pkg::KEY_NAME_W-1:0]   key_name,
    input  logic [qpie_pkg::KEY_LEN_W-1:0]    key_length,
    output qpie_pkg::qpie_result_t            result
);

    localparam int POS_W = $clog2(MAX_KEY_CHARS + 1);
    localparam int CNT_W = $clog2(MAX_VALUE_CHARS + 2);

    logic [POS_W-1:0]            pos_reg,   pos_next;
    qpie_pkg::seg_status_t       seg_reg,   seg_next;
    logic [CNT_W-1:0]            cnt_reg,   cnt_next;
    qpie_pkg::num_phase_t        phase_reg, phase_next;
    logic [qpie_pkg::MAG_W-1:0]  mag_reg,   mag_next;
    logic                        neg_reg,   neg_next;
    logic                        digit_reg, digit_next;
    logic                        match_reg, match_next;

    logic [7:0]                  c;
    logic [7:0]                  key_byte;
    logic [POS_W-1:0]            klen;
    logic                        is_space;
    logic                        is_digit;
    logic [qpie_pkg::MAG_W-1:0]  mag_acc;
    logic [CNT_W-1:0]            cnt_inc;

    assign c        = item.query_byte;
    assign key_byte = key_name[8 * 32'(3'(pos_reg)) +: 8];
    assign klen     = (key_length > qpie_pkg::KEY_LEN_W'(MAX_KEY_CHARS))
                    ? POS_W'(MAX_KEY_CHARS) : POS_W'(key_length);
    assign is_space = (c == qpie_pkg::CHAR_SPACE)
                   || (c >= qpie_pkg::CHAR_TAB && c <= qpie_pkg::CHAR_CR);
    assign is_digit = (c >= qpie_pkg::CHAR_ZERO) && (c <= qpie_pkg::CHAR_NINE);
    // times ten plus the digit
    assign mag_acc  = (mag_reg << 3) + (mag_reg << 1)
                    + qpie_pkg::MAG_W'(c[3:0]);
    assign cnt_inc  = (cnt_reg <= CNT_W'(MAX_VALUE_CHARS)) ? cnt_reg + 1'b1 : cnt_reg;

    // next state
    always_comb
    begin
        pos_next   = pos_reg;
        seg_next   = seg_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        digit_next = digit_reg;
        match_next = match_reg;
        if (seg_reg != qpie_pkg::SEG_DONE)
        begin
            if (c == qpie_pkg::CHAR_AMP)
            begin
                if (seg_reg == qpie_pkg::SEG_VALUE)
                begin
                    seg_next = qpie_pkg::SEG_DONE;
                end
                else
                begin
                    pos_next = '0;
                    seg_next = qpie_pkg::SEG_KEY;
                end
            end
            else if (seg_reg == qpie_pkg::SEG_KEY)
            begin
                if (pos_reg < klen)
                begin
                    if (c == key_byte)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    else
                    begin
                        seg_next = qpie_pkg::SEG_SKIP;
                    end
                end
                else if (c == qpie_pkg::CHAR_EQ)
                begin
                    seg_next   = qpie_pkg::SEG_VALUE;
                    match_next = 1'b1;
                    cnt_next   = '0;
                    phase_next = qpie_pkg::PH_SPACE;
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    digit_next = 1'b0;
                end
                else
                begin
                    seg_next = qpie_pkg::SEG_SKIP;
                end
            end
            else if (seg_reg == qpie_pkg::SEG_VALUE)
            begin
                cnt_next = cnt_inc;
                if (cnt_inc <= CNT_W'(MAX_VALUE_CHARS))
                begin
                    unique case (phase_reg)
                        qpie_pkg::PH_SPACE,
                        qpie_pkg::PH_SIGN,
                        qpie_pkg::PH_DIGITS:
                        begin
                            if (phase_reg == qpie_pkg::PH_SPACE && is_space)
                            begin
                                phase_next = phase_reg;
                            end
                            else if (phase_reg == qpie_pkg::PH_SPACE
                                     && (c == qpie_pkg::CHAR_PLUS
                                         || c == qpie_pkg::CHAR_MINUS))
                            begin
                                neg_next   = (c == qpie_pkg::CHAR_MINUS);
                                phase_next = qpie_pkg::PH_SIGN;
                            end
                            else if (is_digit)
                            begin
                                mag_next   = mag_acc;
                                digit_next = 1'b1;
                                phase_next = qpie_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = qpie_pkg::PH_STOP;
                            end
                        end
                        qpie_pkg::PH_STOP:
                        begin
                            phase_next = phase_reg;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    // result from the state after this byte
    always_comb
    begin
        result.key_found   = match_next;
        result.param_value = '0;
        if (match_next && digit_next && cnt_next <= CNT_W'(MAX_VALUE_CHARS))
        begin
            result.param_value = neg_next
                ? qpie_pkg::VALUE_W'(0) - {1'b0, mag_next}
                : {1'b0, mag_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            seg_reg   <= qpie_pkg::SEG_KEY;
            cnt_reg   <= '0;
            phase_reg <= qpie_pkg::PH_SPACE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            digit_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                pos_reg   <= '0;
                seg_reg   <= qpie_pkg::SEG_KEY;
                cnt_reg   <= '0;
                phase_reg <= qpie_pkg::PH_SPACE;
                mag_reg   <= '0;
                neg_reg   <= 1'b0;
                digit_reg <= 1'b0;
                match_reg <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                seg_reg   <= seg_next;
                cnt_reg   <= cnt_next;
                phase_reg <= phase_next;
                mag_reg   <= mag_next;
                neg_reg   <= neg_next;
                digit_reg <= digit_next;
                match_reg <= match_next;
            end
        end
    end

endmodule

/* rtl/qpie_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpie_out_reg
// result register: holds one result until the consumer takes it
// ----------------------------------------------------------------------------
module qpie_out_reg
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  qpie_pkg::qpie_result_t load_result,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   slot_free,
    output qpie_pkg::qpie_result_t result
);

    logic                   valid_reg;
    logic                   valid_next;
    qpie_pkg::qpie_result_t result_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

/* rtl/qpie_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpie_checker
// port-level checks on the result channel of the extractor
// ----------------------------------------------------------------------------
module qpie_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [qpie_pkg::VALUE_W-1:0] param_value,
    input  logic                                key_found
);

    localparam logic signed [qpie_pkg::VALUE_W-1:0] MAX_PARSED = 31'sd999999999;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(param_value) && $stable(key_found))
        else $error("result changed while stalled");

    // no key match means a zero value
    a_zero_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_found |-> param_value == '0)
        else $error("nonzero value without key match");

    // at most nine digits
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(param_value > MAX_PARSED))
        else $error("value above nine digits");

    // a negative value needs a matched key
    a_neg_matched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && param_value[qpie_pkg::VALUE_W-1] |-> key_found)
        else $error("negative value without key match");

endmodule

bind query_param_int_extractor qpie_checker u_qpie_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .param_value (param_value),
    .key_found   (key_found)
);
